@@ rtl/bfws_pkg.sv @@
// bfws_pkg: sizes, operation codes and beat types of the word-sum bloom filter
// used by bfws_store, bloom_filter_word_sum_top and bfws_checker; no dependencies
package bfws_pkg;

  localparam int FILTER_WORDS = 1024;
  localparam int WORD_BITS    = 64;
  localparam int BIT_SEL_W    = $clog2(WORD_BITS);
  localparam int IDX_BITS     = $clog2(FILTER_WORDS);
  localparam int HASH_W       = IDX_BITS + BIT_SEL_W;
  localparam int ADDR_W       = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int KEY_W        = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key_word;
    logic             word_valid;
    logic             last_word;
  } item_in_t;

  typedef struct packed {
    logic [1:0] done_op;
    logic       maybe_present;
  } item_out_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

endpackage

@@ rtl/bfws_store.sv @@
// bfws_store: filter bit store, one write port and one registered read port
// depends on bfws_pkg
module bfws_store (
  input  logic                           clk,
  input  bfws_pkg::mem_req_t             req,
  output logic [bfws_pkg::WORD_BITS-1:0] rd_data
);

  logic [bfws_pkg::WORD_BITS-1:0] mem [bfws_pkg::FILTER_WORDS];
  logic [bfws_pkg::WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bloom_filter_word_sum_top.sv @@
// bloom_filter_word_sum_top: single-hash bloom filter keyed by a word sum
// depends on bfws_pkg and bfws_store
//
//   channel  ports                       handshake
//   input    start, busy, in_item        beat taken when start && !busy
//   result   out_valid, out_item         one-cycle strobe, cannot be stalled
//
// a key word that is not the last is added into the running sum and busy stays low
// the last word of an insert or check runs as store read, then test or write back;
//   the result strobe follows in the cycle after the test or write back
// a clear sweeps the store one word a cycle over all FILTER_WORDS (1024) words,
//   busy throughout, then strobes its result
// after reset the same sweep runs, busy throughout, with no result
// the receiver cannot stall, so results are never held back
module bloom_filter_word_sum_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfws_pkg::item_in_t  in_item,
  output logic                out_valid,
  output bfws_pkg::item_out_t out_item
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RMW   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // running key hash, truncated to the hash width
  logic [bfws_pkg::HASH_W-1:0]    key_sum_r, key_sum_nxt;
  logic [bfws_pkg::HASH_W-1:0]    sum_add;
  logic [bfws_pkg::ADDR_W-1:0]    clr_ptr_r, clr_ptr_nxt;
  logic                           clr_report_r, clr_report_nxt;
  logic [bfws_pkg::ADDR_W-1:0]    idx_r, idx_nxt;
  logic [bfws_pkg::BIT_SEL_W-1:0] bit_r, bit_nxt;
  logic [1:0]                     op_r, op_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bfws_pkg::item_out_t            out_item_r, out_item_nxt;

  bfws_pkg::mem_req_t             req;
  logic [bfws_pkg::WORD_BITS-1:0] rd_data;
  logic                           accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // word to add, only the hash bits of it matter
  assign sum_add = key_sum_r + (in_item.word_valid ?
                   in_item.key_word[bfws_pkg::HASH_W-1:0] : '0);

  always_comb begin
    state_nxt      = state_r;
    key_sum_nxt    = key_sum_r;
    clr_ptr_nxt    = clr_ptr_r;
    clr_report_nxt = clr_report_r;
    idx_nxt        = idx_r;
    bit_nxt        = bit_r;
    op_nxt         = op_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    req.we         = 1'b0;
    req.waddr      = idx_r;
    req.wdata      = rd_data | ({{(bfws_pkg::WORD_BITS-1){1'b0}}, 1'b1} << bit_r);
    // read address: the hashed word of a key that ends this cycle
    req.raddr      = bfws_pkg::ADDR_W'(sum_add >> bfws_pkg::BIT_SEL_W);

    unique case (state_r)
      S_CLEAR: begin
        // sweep zeros through the store
        req.we      = 1'b1;
        req.waddr   = clr_ptr_r;
        req.wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + bfws_pkg::ADDR_W'(1);
        if (clr_ptr_r == bfws_pkg::ADDR_W'(bfws_pkg::FILTER_WORDS - 1)) begin
          clr_ptr_nxt    = '0;
          clr_report_nxt = 1'b0;
          state_nxt      = S_IDLE;
          if (clr_report_r) begin
            out_valid_nxt              = 1'b1;
            out_item_nxt.done_op       = bfws_pkg::OP_CLEAR;
            out_item_nxt.maybe_present = 1'b0;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_item.op == bfws_pkg::OP_CLEAR) begin
            key_sum_nxt    = '0;
            clr_ptr_nxt    = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = S_CLEAR;
          end else if (in_item.op != bfws_pkg::OP_NONE) begin
            key_sum_nxt = sum_add;
            if (in_item.last_word) begin
              // key ends: latch where to look, restart the sum
              key_sum_nxt = '0;
              idx_nxt     = bfws_pkg::ADDR_W'(sum_add >> bfws_pkg::BIT_SEL_W);
              bit_nxt     = sum_add[bfws_pkg::BIT_SEL_W-1:0];
              op_nxt      = in_item.op;
              state_nxt   = S_RMW;
            end
          end
        end
      end
      S_RMW: begin
        // store word is on rd_data now
        out_valid_nxt        = 1'b1;
        out_item_nxt.done_op = op_r;
        if (op_r == bfws_pkg::OP_INSERT) begin
          req.we                     = 1'b1;
          out_item_nxt.maybe_present = 1'b0;
        end else begin
          out_item_nxt.maybe_present = rd_data[bit_r];
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      key_sum_r    <= '0;
      clr_ptr_r    <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      key_sum_r    <= key_sum_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    op_r       <= op_nxt;
    out_item_r <= out_item_nxt;
  end

  bfws_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/bfws_checker.sv @@
// bfws_checker: port-level assertions for bloom_filter_word_sum_top, bound in below
// depends on bfws_pkg
module bfws_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input bfws_pkg::item_in_t  in_item,
  input logic                out_valid,
  input bfws_pkg::item_out_t out_item
);

  // results never come back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.done_op != bfws_pkg::OP_NONE)
    else $error("result carries unused op code");

  a_present_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.done_op != bfws_pkg::OP_CHECK) |-> !out_item.maybe_present)
    else $error("maybe_present set on non-check result");

  // a key end or a clear always makes the block busy next cycle
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.op == bfws_pkg::OP_CLEAR ||
     (in_item.last_word && in_item.op != bfws_pkg::OP_NONE))) |=> busy)
    else $error("busy not raised after key end or clear");

  // a check or insert result comes right after the read-modify cycle
  a_result_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.done_op != bfws_pkg::OP_CLEAR) |-> $fell(busy))
    else $error("key result not right after busy cycle");

endmodule

bind bloom_filter_word_sum_top bfws_checker u_bfws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
